@@ sv/kvt_pkg.sv @@
package kvt_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int KEY_W            = 32;
    localparam int VALUE_W          = 32;
    localparam int CMD_W            = 2;
    localparam int STATUS_W         = 3;
    localparam int COUNT_OUT_W      = 5;
    localparam int ENTRY_W          = KEY_W + VALUE_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_LIST   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_DUP     = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_MISSING = 3'd3,
        STAT_EMPTY   = 3'd4
    } t_status;

    // one result as it leaves the engine
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   last;
        logic [VALUE_W-1:0]     entry_value;
        logic [KEY_W-1:0]       entry_key;
        logic                   found;
        t_status                status;
    } t_result;

endpackage

@@ sv/kvt_mem.sv @@
module kvt_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        // read data holds while i_re is low
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/kvt_engine.sv @@
module kvt_engine #(
    parameter int CAPACITY = 16,
    parameter int AW       = 4,
    parameter int CW       = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_vld,
    output logic                        o_req_rdy,
    input  kvt_pkg::t_cmd               i_cmd,
    input  logic [kvt_pkg::KEY_W-1:0]   i_key,
    input  logic [kvt_pkg::VALUE_W-1:0] i_value,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [kvt_pkg::ENTRY_W-1:0] o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [kvt_pkg::ENTRY_W-1:0] i_mem_rdata,
    output logic                        o_res_vld,
    output kvt_pkg::t_result            o_res,
    input  logic                        i_res_rdy
);

    import kvt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_RESULT,
        ST_LIST
    } t_state;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [AW-1:0]        r_idx, n_idx;
    logic [AW-1:0]        r_pos, n_pos;
    logic                 r_hit, n_hit;
    logic [CW-1:0]        r_count, n_count;

    logic [CW-1:0]        w_cnt_after;
    logic [CW-1:0]        w_cnt_m1;
    logic [AW-1:0]        w_last_idx;
    logic [AW-1:0]        w_idx_p1;
    logic [KEY_W-1:0]     w_rd_key;
    logic [VALUE_W-1:0]   w_rd_value;
    logic [CW+COUNT_OUT_W-1:0] w_cnt_ext;
    logic                 w_accept;

    assign w_cnt_m1   = r_count - CW'(1);
    assign w_last_idx = w_cnt_m1[AW-1:0];
    assign w_idx_p1   = r_idx + AW'(1);
    assign w_rd_key   = i_mem_rdata[KEY_W-1:0];
    assign w_rd_value = i_mem_rdata[ENTRY_W-1:KEY_W];
    assign w_cnt_ext  = {{COUNT_OUT_W{1'b0}}, w_cnt_after};
    assign o_req_rdy  = (r_state == ST_IDLE);
    assign w_accept   = i_req_vld && o_req_rdy;

    // entry count once the pending request completes
    always_comb begin
        w_cnt_after = r_count;
        if (r_state == ST_RESULT) begin
            if (r_cmd == CMD_INSERT && !r_hit && r_count != CW'(CAPACITY)) begin
                w_cnt_after = r_count + CW'(1);
            end else if (r_cmd == CMD_REMOVE && r_hit) begin
                w_cnt_after = w_cnt_m1;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_value     = r_value;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_hit       = r_hit;
        n_count     = r_count;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos;
        o_mem_wdata = {r_value, r_key};
        o_res_vld   = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;

        unique case (r_state)
            ST_IDLE: begin
                // slot 0 is always prefetched so a scan or listing starts at once
                o_mem_re    = 1'b1;
                o_mem_raddr = '0;
                if (w_accept) begin
                    n_cmd   = i_cmd;
                    n_key   = i_key;
                    n_value = i_value;
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    if (r_count == '0) begin
                        n_state = ST_RESULT;
                    end else if (i_cmd == CMD_LIST) begin
                        n_state = ST_LIST;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = w_idx_p1;
                if (w_rd_key == r_key) begin
                    n_hit   = 1'b1;
                    n_pos   = r_idx;
                    n_state = (r_cmd == CMD_REMOVE) ? ST_TAIL : ST_RESULT;
                end else if (r_idx == w_last_idx) begin
                    n_state = ST_RESULT;
                end else begin
                    n_idx = w_idx_p1;
                end
            end
            ST_TAIL: begin
                // fetch the last entry; it fills the hole left by the removal
                o_mem_re    = 1'b1;
                o_mem_raddr = w_last_idx;
                n_state     = ST_RESULT;
            end
            ST_RESULT: begin
                o_res_vld = 1'b1;
                unique case (r_cmd)
                    CMD_INSERT: begin
                        if (r_hit) begin
                            o_res.status = STAT_DUP;
                            o_res.found  = 1'b1;
                        end else if (r_count == CW'(CAPACITY)) begin
                            o_res.status = STAT_FULL;
                        end else begin
                            o_res.status = STAT_OK;
                            o_mem_we     = i_res_rdy;
                            o_mem_waddr  = r_count[AW-1:0];
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_hit) begin
                            o_res.status = STAT_OK;
                            o_res.found  = 1'b1;
                            o_mem_we     = i_res_rdy;
                            o_mem_waddr  = r_pos;
                            o_mem_wdata  = i_mem_rdata;
                        end else begin
                            o_res.status = STAT_MISSING;
                        end
                    end
                    CMD_QUERY: begin
                        o_res.status = r_hit ? STAT_OK : STAT_MISSING;
                        o_res.found  = r_hit;
                    end
                    CMD_LIST: begin
                        // only reached here when the table is empty
                        o_res.status = STAT_EMPTY;
                    end
                    default: begin
                        o_res.status = STAT_MISSING;
                    end
                endcase
                o_res.entry_count = w_cnt_ext[COUNT_OUT_W-1:0];
                if (i_res_rdy) begin
                    n_count = w_cnt_after;
                    n_state = ST_IDLE;
                end
            end
            ST_LIST: begin
                o_res_vld         = 1'b1;
                o_res.status      = STAT_OK;
                o_res.entry_key   = w_rd_key;
                o_res.entry_value = w_rd_value;
                o_res.last        = (r_idx == w_last_idx);
                o_res.entry_count = w_cnt_ext[COUNT_OUT_W-1:0];
                if (i_res_rdy) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = w_idx_p1;
                    n_idx       = w_idx_p1;
                    if (r_idx == w_last_idx) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_value <= n_value;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_hit   <= n_hit;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == ST_RESULT && i_res_rdy))
        else $error("table write outside result delivery");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_LIST) |-> (r_count != '0))
        else $error("scan of an empty table");

    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LIST && i_res_rdy && r_idx == w_last_idx) |=> (r_state == ST_IDLE))
        else $error("listing did not stop at the last entry");

endmodule

@@ sv/unique_key_value_table_top.sv @@
// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tuser: command; tdata: key, value
// m_axis    out  m_axis_tvalid/tready    tdata: status, found, entry_key, entry_value,
//                                        entry_count; tlast: last
//
// Requests are handled one at a time. Insert, remove and query accept the request,
//   compare the stored slots in turn until a match through the single read port, fetch
//   the tail entry on a remove, and deliver the result. A listing delivers one entry per
//   cycle while m_axis is not stalled.
// Reset: i_rst_n synchronous, active low; empties the table. No clearing pass.
// Stalls: a result register sits on m_axis, so the next request can be taken while
//   the previous result is still waiting; a listing pauses while m_axis is stalled.
module unique_key_value_table_top #(
    parameter int CAPACITY = kvt_pkg::DEFAULT_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [2:0] status, [3] found, [35:4] entry_key,
                                        // [67:36] entry_value, [72:68] entry_count, rest 0
    output logic        m_axis_tlast    // last
);

    import kvt_pkg::*;

    // address width of the entry memory, count width able to hold CAPACITY itself
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic               w_mem_we;
    logic [AW-1:0]      w_mem_waddr;
    logic [ENTRY_W-1:0] w_mem_wdata;
    logic               w_mem_re;
    logic [AW-1:0]      w_mem_raddr;
    logic [ENTRY_W-1:0] w_mem_rdata;

    logic               w_res_vld;
    logic               w_res_rdy;
    t_result            w_res;

    logic               r_out_vld;
    t_result            r_out;

    kvt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (ENTRY_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    kvt_engine #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_vld   (s_axis_tvalid),
        .o_req_rdy   (s_axis_tready),
        .i_cmd       (t_cmd'(s_axis_tuser)),
        .i_key       (s_axis_tdata[KEY_W-1:0]),
        .i_value     (s_axis_tdata[ENTRY_W-1:KEY_W]),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_re    (w_mem_re),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata),
        .o_res_vld   (w_res_vld),
        .o_res       (w_res),
        .i_res_rdy   (w_res_rdy)
    );

    // output register: free when empty or being drained this cycle
    assign w_res_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_rdy) begin
            r_out_vld <= w_res_vld;
        end
        if (w_res_vld && w_res_rdy) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {7'd0, r_out.entry_count, r_out.entry_value, r_out.entry_key,
                            r_out.found, r_out.status};

endmodule

@@ dv/tb.sv @@
module tb;

    import kvt_pkg::*;

    localparam int CAP         = DEFAULT_CAPACITY;
    localparam int PHASE_ITEMS = 68;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 400000;

    // Tracks the table contents and holds the results still owed by the block.
    class table_tracker;
        logic [KEY_W-1:0]   key_slot   [CAP];
        logic [VALUE_W-1:0] value_slot [CAP];
        int unsigned        fill;
        t_result            owed[$];
        int unsigned        mismatch_count;
        int unsigned        results_checked;
        int unsigned        full_rejects;
        int unsigned        dup_rejects;
        int unsigned        empty_lists;
        int unsigned        cmd_seen [4];

        function int find_slot(logic [KEY_W-1:0] k);
            for (int i = 0; i < fill; i++) begin
                if (key_slot[i] == k) return i;
            end
            return -1;
        endfunction

        function void owe(t_status st, logic hit, logic [KEY_W-1:0] k,
                          logic [VALUE_W-1:0] v, logic fin);
            t_result r;
            r.status      = st;
            r.found       = hit;
            r.entry_key   = k;
            r.entry_value = v;
            r.last        = fin;
            r.entry_count = fill[COUNT_OUT_W-1:0];
            owed.push_back(r);
        endfunction

        // Apply one accepted request to the tracked table and queue its results.
        function void record_command(t_cmd cmd, logic [KEY_W-1:0] k,
                                     logic [VALUE_W-1:0] v);
            int pos;
            cmd_seen[cmd]++;
            pos = find_slot(k);
            case (cmd)
                CMD_LIST: begin
                    if (fill == 0) begin
                        empty_lists++;
                        owe(STAT_EMPTY, 1'b0, '0, '0, 1'b1);
                    end else begin
                        for (int i = 0; i < fill; i++)
                            owe(STAT_OK, 1'b0, key_slot[i], value_slot[i], i == fill - 1);
                    end
                end
                CMD_INSERT: begin
                    if (pos >= 0) begin
                        dup_rejects++;
                        owe(STAT_DUP, 1'b1, '0, '0, 1'b1);
                    end else if (fill >= CAP) begin
                        full_rejects++;
                        owe(STAT_FULL, 1'b0, '0, '0, 1'b1);
                    end else begin
                        key_slot[fill]   = k;
                        value_slot[fill] = v;
                        fill++;
                        owe(STAT_OK, 1'b0, '0, '0, 1'b1);
                    end
                end
                CMD_REMOVE: begin
                    if (pos < 0) begin
                        owe(STAT_MISSING, 1'b0, '0, '0, 1'b1);
                    end else begin
                        // tail entry fills the hole so the table stays packed
                        key_slot[pos]   = key_slot[fill-1];
                        value_slot[pos] = value_slot[fill-1];
                        fill--;
                        owe(STAT_OK, 1'b1, '0, '0, 1'b1);
                    end
                end
                default: begin
                    if (pos < 0) owe(STAT_MISSING, 1'b0, '0, '0, 1'b1);
                    else         owe(STAT_OK, 1'b1, '0, '0, 1'b1);
                end
            endcase
        endfunction

        task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                     results_checked, what, got, want);
            mismatch_count++;
        endtask

        task check_response(logic [79:0] data, logic tlast);
            t_result want;
            if (owed.size() == 0) begin
                flag_mismatch("result with nothing owed, tdata", data[63:0], 64'd0);
                return;
            end
            want = owed.pop_front();
            if (data[2:0] !== want.status)       flag_mismatch("status", data[2:0], want.status);
            if (data[3] !== want.found)          flag_mismatch("found", data[3], want.found);
            if (data[35:4] !== want.entry_key)   flag_mismatch("entry_key", data[35:4],
                                                               want.entry_key);
            if (data[67:36] !== want.entry_value) flag_mismatch("entry_value", data[67:36],
                                                                want.entry_value);
            if (data[72:68] !== want.entry_count) flag_mismatch("entry_count", data[72:68],
                                                                want.entry_count);
            if (data[79:73] !== '0)              flag_mismatch("padding", data[79:73], 64'd0);
            if (tlast !== want.last)             flag_mismatch("tlast", tlast, want.last);
            results_checked++;
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [1:0]  s_axis_tuser;    // [1:0] command
    logic [63:0] s_axis_tdata;    // [31:0] key, [63:32] value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;    // [2:0] status, [3] found, [35:4] entry_key,
                                  // [67:36] entry_value, [72:68] entry_count, rest 0
    logic        m_axis_tlast;    // last

    table_tracker table_model;
    int unsigned  idle_pct;       // sender gap chance per cycle
    int unsigned  stall_pct;      // receiver stall chance per cycle
    int unsigned  cycle_count;
    bit           growing;        // random part drifts toward full when set

    unique_key_value_table_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cycle_count   = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        growing       = 1'b1;
        table_model   = new();
    end

    always #2 i_clk = ~i_clk;

    // Run guard: sized well past a worst case of full listings under long stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Downstream back-pressure, redrawn each cycle.
    always @(negedge i_clk) begin
        m_axis_tready = ($urandom_range(99) >= stall_pct);
    end

    // Every accepted result goes against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            table_model.check_response(m_axis_tdata, m_axis_tlast);
    end

    // Drive one request; entered and left at a falling edge. The tracker is
    // updated at the accepting edge so the next request sees current contents.
    task send_request(t_cmd cmd, logic [KEY_W-1:0] k, logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = {v, k};
        do @(posedge i_clk); while (!s_axis_tready);
        table_model.record_command(cmd, k, v);
        @(negedge i_clk);
    endtask

    // Key for a remove or query or insert: often one already stored so hits and
    // duplicates happen, sometimes an edge value, otherwise fully random.
    function logic [KEY_W-1:0] pick_key(int unsigned stored_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (table_model.fill > 0 && r < stored_pct)
            return table_model.key_slot[$urandom_range(table_model.fill - 1)];
        if (r >= 95) return '0;
        if (r >= 90) return '1;
        return $urandom;
    endfunction

    task random_request();
        int unsigned r;
        t_cmd        cmd;
        // sweep between empty and full; linger at full to hit the full reject
        if (table_model.fill == 0)
            growing = 1'b1;
        else if (table_model.fill == CAP && $urandom_range(99) < 30)
            growing = 1'b0;
        else if ($urandom_range(99) < 3)
            growing = ~growing;
        r = $urandom_range(99);
        if (r < 8)
            cmd = CMD_LIST;
        else if (r < 28)
            cmd = CMD_QUERY;
        else if (r < (growing ? 78 : 48))
            cmd = CMD_INSERT;
        else
            cmd = CMD_REMOVE;
        send_request(cmd, pick_key(cmd == CMD_INSERT ? 20 : 60), $urandom);
    endtask

    initial begin
        int unsigned settle;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_pct  = 17;
        stall_pct = 52;

        // directed: empty-table behavior, edge keys, duplicate, swap-on-remove,
        // fill to capacity, reject when full, full listing
        send_request(CMD_LIST,   32'h1234_5678, 32'h9abc_def0);
        send_request(CMD_QUERY,  32'h0000_0001, '0);
        send_request(CMD_REMOVE, 32'h0000_0001, '0);
        send_request(CMD_INSERT, '0, '0);
        send_request(CMD_INSERT, '1, '1);
        send_request(CMD_INSERT, '0, 32'h5555_aaaa);
        send_request(CMD_QUERY,  '1, '0);
        send_request(CMD_QUERY,  32'h8000_0000, '0);
        send_request(CMD_REMOVE, '0, '0);              // head slot takes the tail entry
        for (int i = 0; i < CAP - 1; i++)
            send_request(CMD_INSERT, 32'ha5a5_0000 | i, $urandom);
        send_request(CMD_INSERT, 32'h0bad_cafe, '1);   // table full
        send_request(CMD_LIST,   '0, '0);

        for (int n = 0; n < PHASE_ITEMS; n++) random_request();
        idle_pct  = 52;
        stall_pct = 17;
        for (int n = 0; n < PHASE_ITEMS; n++) random_request();
        idle_pct  = 0;
        stall_pct = 0;
        for (int n = 0; n < PHASE_ITEMS; n++) random_request();
        s_axis_tvalid = 1'b0;

        while (table_model.owed.size() != 0) @(posedge i_clk);
        // watch for stray results after the last one owed
        for (settle = 0; settle < SETTLE; settle++) @(posedge i_clk);
        if (table_model.owed.size() != 0)
            table_model.flag_mismatch("results never delivered",
                                      table_model.owed.size(), 64'd0);

        $display("Covered %0d inserts, %0d removes, %0d queries, %0d listings; %0d results checked",
                 table_model.cmd_seen[CMD_INSERT], table_model.cmd_seen[CMD_REMOVE],
                 table_model.cmd_seen[CMD_QUERY], table_model.cmd_seen[CMD_LIST],
                 table_model.results_checked);
        $display("Duplicate rejects %0d, full-table rejects %0d, empty listings %0d",
                 table_model.dup_rejects, table_model.full_rejects, table_model.empty_lists);
        if (table_model.mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
